// ===== hdl/ps2md_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2md_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_TYPE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_CAPABLE = 1'd1;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [7:0] WHEEL_ID = 8'd3;

    localparam logic [2:0] LEN_PLAIN = 3'd3;
    localparam logic [2:0] LEN_WHEEL = 3'd4;

    localparam logic [7:0] BTN_MASK   = 8'h07;
    localparam int         X_SIGN_POS = 4;
    localparam int         Y_SIGN_POS = 5;
    localparam int         X_OVF_POS  = 6;
    localparam int         Y_OVF_POS  = 7;

    typedef struct packed {
        logic [2:0]        buttons;
        logic signed [8:0] x_move;
        logic signed [9:0] y_move;
        logic signed [7:0] wheel_move;
        logic [7:0]        source_id;
    } t_event;

endpackage

// ===== hdl/ps2md_in_if.sv =====
// Input channel: one received byte or one pop request per item.
interface ps2md_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       aux_ready;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output aux_ready, output data_byte,
                    input ready);
    modport sink (input valid, input mode, input aux_ready, input data_byte,
                  output ready);
endinterface

// ===== hdl/ps2md_out_if.sv =====
// Output channel: one status and event result per item.
interface ps2md_out_if;
    logic              valid;
    logic              ready;
    logic              event_valid;
    logic [2:0]        buttons;
    logic signed [8:0] x_move;
    logic signed [9:0] y_move;
    logic signed [7:0] wheel_move;
    logic [7:0]        source_id;
    logic              events_waiting;
    logic              byte_dropped;

    modport source (output valid, output event_valid, output buttons, output x_move,
                    output y_move, output wheel_move, output source_id,
                    output events_waiting, output byte_dropped, input ready);
    modport sink (input valid, input event_valid, input buttons, input x_move,
                  input y_move, input wheel_move, input source_id,
                  input events_waiting, input byte_dropped, output ready);
endinterface

// ===== hdl/ps2_mouse_packet_decoder.sv =====
// Top level of the PS/2 mouse packet decoder with its event queue.
//
// Each input item is either a byte from the controller (mode 0) or a pop
// request (mode 1). Bytes flagged as auxiliary are gathered into 3-byte
// packets, or 4-byte packets when the device is wheel capable with ID 3.
// A finished packet is decoded and pushed into a ring of QUEUE_DEPTH slots,
// one of which always stays empty; when the ring is full the event is lost
// and byte_dropped is set. A pop returns the oldest event.
// Every input item yields exactly one result item carrying status.
// The accepting edge registers the queue read and the status of an item in the
// middle stage; the result register loads from that stage once it is free, so a
// stall can hold a result back. One item is accepted per cycle while input ready is high.
// When the receiver stalls, the result register and the stage before it fill,
// and input ready drops only once both are occupied. Configuration is to be
// written through the plain write port only while idle; the block never checks.
// Reset clears the packet phase, the queue pointers and both configuration
// registers; the queue memory itself is not cleared.
module ps2_mouse_packet_decoder #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ps2md_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ps2md_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ps2md_in_if.sink                         i_in_ch,
    ps2md_out_if.source                      o_out_ch
);
    import ps2md_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [7:0]       r_device_type;
    logic             r_scroll_capable;
    logic [1:0]       r_byte_phase;
    logic [7:0]       r_pkt_b0;
    logic [7:0]       r_pkt_b1;
    logic [7:0]       r_pkt_b2;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_wr_idx;
    t_event           r_event_mem [QUEUE_DEPTH];
    t_event           r_rd_data;

    logic r_s1_valid;
    logic r_s1_hit;
    logic r_s1_waiting;
    logic r_s1_dropped;

    logic              r_out_valid;
    logic              r_out_event_valid;
    logic [2:0]        r_out_buttons;
    logic signed [8:0] r_out_x_move;
    logic signed [9:0] r_out_y_move;
    logic signed [7:0] r_out_wheel_move;
    logic [7:0]        r_out_source_id;
    logic              r_out_waiting;
    logic              r_out_dropped;

    logic             in_fire;
    logic             out_free;
    logic             s1_move;
    logic             is_pop;
    logic             pop_hit;
    logic             byte_fire;
    logic [2:0]       pkt_len;
    logic [2:0]       phase_inc;
    logic             pkt_done;
    logic             four_byte;
    logic [7:0]       last_b2;
    logic [8:0]       x_raw;
    logic [9:0]       y_raw;
    logic [IDX_W-1:0] wr_idx_inc;
    logic [IDX_W-1:0] rd_idx_inc;
    logic             q_full;
    logic             push;
    logic             drop;
    logic [IDX_W-1:0] n_rd_idx;
    logic [IDX_W-1:0] n_wr_idx;
    logic [1:0]       n_byte_phase;
    t_event           new_event;

    // The middle stage may advance whenever the result register is free or
    // being emptied; input is taken whenever the middle stage can make room.
    assign out_free       = !r_out_valid || o_out_ch.ready;
    assign s1_move        = r_s1_valid && out_free;
    assign i_in_ch.ready  = !r_s1_valid || out_free;
    assign in_fire        = i_in_ch.valid && i_in_ch.ready;

    assign is_pop    = (i_in_ch.mode == MODE_POP);
    assign pop_hit   = in_fire && is_pop && (r_rd_idx != r_wr_idx);
    assign byte_fire = in_fire && !is_pop && i_in_ch.aux_ready;

    // The packet size is checked against the configuration in force at each byte.
    assign pkt_len   = (r_scroll_capable && (r_device_type == WHEEL_ID)) ? LEN_WHEEL
                                                                         : LEN_PLAIN;
    assign phase_inc = {1'b0, r_byte_phase} + 3'd1;
    assign pkt_done  = (phase_inc >= pkt_len);
    assign four_byte = (phase_inc == LEN_WHEEL) && (pkt_len == LEN_WHEEL);

    // A 3-byte packet completes on the byte that would land in slot two.
    assign last_b2 = (r_byte_phase == 2'd2) ? i_in_ch.data_byte : r_pkt_b2;
    assign x_raw   = {r_pkt_b0[X_SIGN_POS], r_pkt_b1};
    assign y_raw   = 10'd0 - {r_pkt_b0[Y_SIGN_POS], r_pkt_b0[Y_SIGN_POS], last_b2};

    always_comb begin
        new_event.buttons    = 3'(r_pkt_b0 & BTN_MASK);
        new_event.x_move     = r_pkt_b0[X_OVF_POS] ? 9'sd0 : $signed(x_raw);
        new_event.y_move     = r_pkt_b0[Y_OVF_POS] ? 10'sd0 : $signed(y_raw);
        new_event.wheel_move = four_byte ? $signed(i_in_ch.data_byte) : 8'sd0;
        new_event.source_id  = r_device_type;
    end

    assign wr_idx_inc = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
    assign rd_idx_inc = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
    assign q_full     = (wr_idx_inc == r_rd_idx);
    assign push       = byte_fire && pkt_done && !q_full;
    assign drop       = byte_fire && pkt_done && q_full;
    assign n_rd_idx   = pop_hit ? rd_idx_inc : r_rd_idx;
    assign n_wr_idx   = push ? wr_idx_inc : r_wr_idx;

    always_comb begin
        n_byte_phase = r_byte_phase;
        if (byte_fire) begin
            n_byte_phase = pkt_done ? 2'd0 : phase_inc[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_type    <= '0;
            r_scroll_capable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_TYPE:    r_device_type    <= i_cfg_data;
                CFG_SCROLL_CAPABLE: r_scroll_capable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_phase <= '0;
            r_rd_idx     <= '0;
            r_wr_idx     <= '0;
        end else begin
            r_byte_phase <= n_byte_phase;
            r_rd_idx     <= n_rd_idx;
            r_wr_idx     <= n_wr_idx;
        end
    end

    // Stored packet bytes; a fourth byte is used directly and never stored.
    always_ff @(posedge i_clk) begin
        if (byte_fire) begin
            case (r_byte_phase)
                2'd0:    r_pkt_b0 <= i_in_ch.data_byte;
                2'd1:    r_pkt_b1 <= i_in_ch.data_byte;
                2'd2:    r_pkt_b2 <= i_in_ch.data_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_event_mem[r_wr_idx] <= new_event;
        end
        if (pop_hit) begin
            r_rd_data <= r_event_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_hit     <= pop_hit;
            r_s1_waiting <= (n_rd_idx != n_wr_idx);
            r_s1_dropped <= drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_event_valid <= r_s1_hit;
            r_out_buttons     <= r_s1_hit ? r_rd_data.buttons : 3'd0;
            r_out_x_move      <= r_s1_hit ? r_rd_data.x_move : 9'sd0;
            r_out_y_move      <= r_s1_hit ? r_rd_data.y_move : 10'sd0;
            r_out_wheel_move  <= r_s1_hit ? r_rd_data.wheel_move : 8'sd0;
            r_out_source_id   <= r_s1_hit ? r_rd_data.source_id : 8'd0;
            r_out_waiting     <= r_s1_waiting;
            r_out_dropped     <= r_s1_dropped;
        end
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.event_valid    = r_out_event_valid;
    assign o_out_ch.buttons        = r_out_buttons;
    assign o_out_ch.x_move         = r_out_x_move;
    assign o_out_ch.y_move         = r_out_y_move;
    assign o_out_ch.wheel_move     = r_out_wheel_move;
    assign o_out_ch.source_id      = r_out_source_id;
    assign o_out_ch.events_waiting = r_out_waiting;
    assign o_out_ch.byte_dropped   = r_out_dropped;

endmodule

// ===== dv/ps2_mouse_packet_decoder_test.sv =====
// Self-checking testbench for the PS/2 mouse packet decoder and its event queue.
module ps2_mouse_packet_decoder_test;
    import ps2md_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;

    // One status item as the decoder returns it.
    typedef struct packed {
        logic   event_valid;
        t_event ev;
        logic   events_waiting;
        logic   byte_dropped;
    } t_status;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] cfg_index;
        logic [CFG_DATA_W-1:0]  cfg_value;
        logic                   mode;
        logic                   aux;
        logic [7:0]             data;
        logic                   typed;
        t_status                want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    ps2md_in_if  in_ch ();
    ps2md_out_if out_ch ();

    ps2_mouse_packet_decoder #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    // Predictor state: register copies, packet assembly and the event ring.
    logic [7:0] dev_type;
    logic       scroll_en;
    logic [1:0] pkt_phase;
    logic [7:0] pkt_byte [3];
    t_event     event_ring [$];

    t_status pending_results [$];

    int n_errors;
    int n_items;
    int n_packets;
    int n_popped;
    int n_empty_pops;
    int n_drops;
    int cycle_count = 0;
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver either sits out a requested hold-off or stalls at random.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic string status_text(input t_status s);
        return $sformatf("valid=%0b btn=%0d x=%0d y=%0d wheel=%0d id=%0d waiting=%0b dropped=%0b",
                         s.event_valid, s.ev.buttons, s.ev.x_move, s.ev.y_move,
                         s.ev.wheel_move, s.ev.source_id, s.events_waiting, s.byte_dropped);
    endfunction

    always @(posedge i_clk) begin : result_check
        t_status seen;
        t_status want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen = '{out_ch.event_valid,
                     '{out_ch.buttons, out_ch.x_move, out_ch.y_move,
                       out_ch.wheel_move, out_ch.source_id},
                     out_ch.events_waiting, out_ch.byte_dropped};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: %s", $time, status_text(seen));
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (seen !== want) begin
                    $display("%0t: mismatch, expected %s", $time, status_text(want));
                    $display("%0t:           got      %s", $time, status_text(seen));
                    n_errors++;
                end
            end
        end
    end

    // Works out the status item that one accepted input item causes.
    function automatic t_status decode_item(input logic mode, input logic aux,
                                            input logic [7:0] data);
        t_status    res;
        t_event     ev;
        logic [2:0] phase;
        logic [2:0] pkt_len;
        logic [7:0] b0;
        res = '0;
        ev = '0;
        if (mode == MODE_POP) begin
            if (event_ring.size() != 0) begin
                res.event_valid = 1'b1;
                res.ev = event_ring.pop_front();
                n_popped++;
            end else begin
                n_empty_pops++;
            end
        end else if (aux) begin
            pkt_len = (scroll_en && dev_type == WHEEL_ID) ? LEN_WHEEL : LEN_PLAIN;
            phase = {1'b0, pkt_phase};
            // A fourth byte is never stored; it only supplies the wheel value.
            if (phase < LEN_PLAIN)
                pkt_byte[phase[1:0]] = data;
            phase = phase + 3'd1;
            if (phase >= pkt_len) begin
                pkt_phase = 2'd0;
                b0 = pkt_byte[0];
                ev.buttons = 3'(b0 & BTN_MASK);
                ev.x_move = $signed({b0[X_SIGN_POS], pkt_byte[1]});
                ev.y_move = -$signed({b0[Y_SIGN_POS], b0[Y_SIGN_POS], pkt_byte[2]});
                if (b0[X_OVF_POS])
                    ev.x_move = '0;
                if (b0[Y_OVF_POS])
                    ev.y_move = '0;
                ev.wheel_move = (phase == LEN_WHEEL && pkt_len == LEN_WHEEL) ? data : 8'h00;
                ev.source_id = dev_type;
                n_packets++;
                if (event_ring.size() < QUEUE_DEPTH - 1) begin
                    event_ring.push_back(ev);
                end else begin
                    res.byte_dropped = 1'b1;
                    n_drops++;
                end
            end else begin
                pkt_phase = phase[1:0];
            end
        end
        res.events_waiting = (event_ring.size() != 0);
        return res;
    endfunction

    task automatic send_item(input logic mode, input logic aux, input logic [7:0] data,
                             input logic typed, input t_status want);
        t_status res;
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.aux_ready <= aux;
        in_ch.data_byte <= data;
        do @(posedge i_clk); while (!in_ch.ready);
        res = decode_item(mode, aux, data);
        pending_results.push_back(typed ? want : res);
        n_items++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DEVICE_TYPE)
            dev_type = val;
        else if (idx == CFG_SCROLL_CAPABLE)
            scroll_en = val[0];
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly whole packets with random content, mixed with pops, stray bytes
    // that break the framing, and bytes from the keyboard port.
    task automatic random_traffic(input int n_target);
        int done_items;
        int pop_pct;
        int burst;
        int pick;
        int n_bytes;
        done_items = 0;
        pop_pct = 25;
        burst = 0;
        while (done_items < n_target) begin
            if (burst == 0) begin
                burst = 30;
                case ($urandom_range(2))
                    0: pop_pct = 5;
                    1: pop_pct = 25;
                    default: pop_pct = 60;
                endcase
            end
            burst--;
            pick = $urandom_range(99);
            if (pick < pop_pct) begin
                send_item(MODE_POP, 1'($urandom), rand_byte(), 1'b0, '0);
                done_items++;
            end else if (pick < pop_pct + 10) begin
                send_item(MODE_BYTE, 1'($urandom), rand_byte(), 1'b0, '0);
                done_items++;
            end else begin
                n_bytes = (scroll_en && dev_type == WHEEL_ID) ? 4 : 3;
                for (int k = 0; k < n_bytes; k++)
                    send_item(MODE_BYTE, 1'b1, rand_byte(), 1'b0, '0);
                done_items += n_bytes;
            end
        end
    endtask

    function automatic t_row item_row(input logic mode, input logic aux, input logic [7:0] data);
        return '{1'b0, CFG_DEVICE_TYPE, 8'h00, mode, aux, data, 1'b0, '0};
    endfunction

    function automatic t_row typed_row(input logic mode, input logic aux, input logic [7:0] data,
                                       input t_status want);
        return '{1'b0, CFG_DEVICE_TYPE, 8'h00, mode, aux, data, 1'b1, want};
    endfunction

    function automatic t_row cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        return '{1'b1, idx, val, MODE_BYTE, 1'b0, 8'h00, 1'b0, '0};
    endfunction

    // Status with no event and only the queue flag given.
    function automatic t_status quiet(input logic waiting);
        return '{1'b0, '0, waiting, 1'b0};
    endfunction

    initial begin
        t_row directed [$];
        n_errors = 0;
        n_items = 0;
        n_packets = 0;
        n_popped = 0;
        n_empty_pops = 0;
        n_drops = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        dev_type = 8'h00;
        scroll_en = 1'b0;
        pkt_phase = 2'd0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_DEVICE_TYPE;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= MODE_BYTE;
        in_ch.aux_ready <= 1'b0;
        in_ch.data_byte <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pop after reset, then a keyboard byte that must be ignored.
        directed.push_back(typed_row(MODE_POP, 1'b0, 8'h00, quiet(1'b0)));
        directed.push_back(typed_row(MODE_BYTE, 1'b0, 8'hFF, quiet(1'b0)));
        // All buttons, largest positive X, zero Y.
        directed.push_back(typed_row(MODE_BYTE, 1'b1, 8'h07, quiet(1'b0)));
        directed.push_back(typed_row(MODE_BYTE, 1'b1, 8'hFF, quiet(1'b0)));
        directed.push_back(typed_row(MODE_BYTE, 1'b1, 8'h00, quiet(1'b1)));
        directed.push_back(typed_row(MODE_POP, 1'b0, 8'h00,
            '{1'b1, '{3'd7, 9'sd255, 10'sd0, 8'sd0, 8'd0}, 1'b0, 1'b0}));
        // Both sign bits with zero magnitude: most negative X, most positive Y.
        directed.push_back(typed_row(MODE_BYTE, 1'b1, 8'h30, quiet(1'b0)));
        directed.push_back(typed_row(MODE_BYTE, 1'b1, 8'h00, quiet(1'b0)));
        directed.push_back(typed_row(MODE_BYTE, 1'b1, 8'h00, quiet(1'b1)));
        directed.push_back(typed_row(MODE_POP, 1'b1, 8'hFF,
            '{1'b1, '{3'd0, 9'sh100, 10'sd256, 8'sd0, 8'd0}, 1'b0, 1'b0}));
        // Wheel packets: most negative wheel and most negative Y.
        directed.push_back(cfg_row(CFG_DEVICE_TYPE, WHEEL_ID));
        directed.push_back(cfg_row(CFG_SCROLL_CAPABLE, 8'h01));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h09));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h01));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'hFF));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h80));
        directed.push_back(typed_row(MODE_POP, 1'b0, 8'h00,
            '{1'b1, '{3'd1, 9'sd1, -10'sd255, 8'sh80, 8'd3}, 1'b0, 1'b0}));
        // Three bytes at size four, then the size drops to three: the fourth
        // byte closes the packet without a wheel value. The scroll write also
        // checks that only bit 0 of the data is kept.
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h18));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h7F));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h01));
        directed.push_back(cfg_row(CFG_SCROLL_CAPABLE, 8'h02));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'hAA));
        // Two bytes at size three, then size four: both overflow bits set.
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'hC5));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h80));
        directed.push_back(cfg_row(CFG_SCROLL_CAPABLE, 8'h01));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h7F));
        directed.push_back(item_row(MODE_BYTE, 1'b1, 8'h7F));
        directed.push_back(item_row(MODE_POP, 1'b0, 8'h00));
        directed.push_back(item_row(MODE_POP, 1'b0, 8'h00));

        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                write_reg(directed[i].cfg_index, directed[i].cfg_value);
            else
                send_item(directed[i].mode, directed[i].aux, directed[i].data,
                          directed[i].typed, directed[i].want);
        end

        // Long receiver hold-off while bytes keep coming: the pipeline backs up
        // and the event ring overflows. Then drain it past empty.
        hold_cycles = 100;
        repeat (72) send_item(MODE_BYTE, 1'b1, rand_byte(), 1'b0, '0);
        wait_idle();
        repeat (QUEUE_DEPTH + 1) send_item(MODE_POP, 1'b0, 8'h00, 1'b0, '0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 50; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 50; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                case (seg)
                    0: begin
                        write_reg(CFG_DEVICE_TYPE, WHEEL_ID);
                        write_reg(CFG_SCROLL_CAPABLE, 8'h01);
                    end
                    1: begin
                        write_reg(CFG_DEVICE_TYPE, ($urandom_range(1) == 0) ? WHEEL_ID
                                                                             : rand_byte());
                        write_reg(CFG_SCROLL_CAPABLE, rand_byte());
                    end
                    default: begin
                        write_reg(CFG_DEVICE_TYPE, (ph % 2 == 0) ? 8'hFF : 8'h00);
                        write_reg(CFG_SCROLL_CAPABLE, 8'($urandom));
                    end
                endcase
                random_traffic(80);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            n_errors++;
        end
        $display("Sent %0d items: %0d packets decoded, %0d dropped on a full queue,",
                 n_items, n_packets, n_drops);
        $display("%0d events popped, %0d pops on an empty queue, %0d mismatches.",
                 n_popped, n_empty_pops, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
